// File: hdl/knl_pkg.sv
// ----------------------------------------------------------------------------
// knl_pkg
// shared constants, op codes and cell control types of the k-nearest list
// ----------------------------------------------------------------------------
package knl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int INDEX_WIDTH_DEF = 24;

    localparam int DIST_W    = 32;
    localparam int OP_W      = 2;
    localparam int CNT_OUT_W = 5;
    localparam int POS_OUT_W = 4;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // op codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    // per-cell control from the sequencer
    typedef struct packed {
        logic occupied;   // cell holds an entry
        logic below;      // cell lies below the insertion boundary
        logic boundary;   // cell is the insertion boundary
        logic cmp;        // compare pass
        logic upd;        // shift/insert pass
    } t_cell_ctl;

    // per-cell compare flags
    typedef struct packed {
        logic shift;      // cell takes its neighbor's entry or the candidate
        logic gt;         // held distance above candidate
        logic eq;         // held distance equals candidate
    } t_cell_sts;

endpackage

// File: hdl/knl_in_if.sv
// ----------------------------------------------------------------------------
// knl_in_if
// op channel into the k-nearest list
// ----------------------------------------------------------------------------
interface knl_in_if #(
    parameter int INDEX_WIDTH = knl_pkg::INDEX_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic [knl_pkg::OP_W-1:0]    op;
    logic [knl_pkg::DIST_W-1:0]  distance;
    logic [INDEX_WIDTH-1:0]      point_index;

    modport source (output valid, output op, output distance, output point_index,
                    input ready);
    modport sink   (input valid, input op, input distance, input point_index,
                    output ready);
endinterface

// File: hdl/knl_out_if.sv
// ----------------------------------------------------------------------------
// knl_out_if
// result channel out of the k-nearest list
// ----------------------------------------------------------------------------
interface knl_out_if #(
    parameter int INDEX_WIDTH = knl_pkg::INDEX_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic [knl_pkg::CNT_OUT_W-1:0]   entry_count;
    logic [knl_pkg::DIST_W-1:0]      worst_distance;
    logic [knl_pkg::DIST_W-1:0]      entry_distance;
    logic [INDEX_WIDTH-1:0]          entry_index;
    logic [knl_pkg::POS_OUT_W-1:0]   position;
    logic                            entry_valid;
    logic                            last;

    modport source (output valid, output accepted, output entry_count,
                    output worst_distance, output entry_distance, output entry_index,
                    output position, output entry_valid, output last, input ready);
    modport sink   (input valid, input accepted, input entry_count,
                    input worst_distance, input entry_distance, input entry_index,
                    input position, input entry_valid, input last, output ready);
endinterface

// File: hdl/knl_cell.sv
// ----------------------------------------------------------------------------
// knl_cell
// one rank of the sorted list: holds an entry, compares, shifts up on insert
// ----------------------------------------------------------------------------
module knl_cell #(
    parameter int INDEX_WIDTH = knl_pkg::INDEX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  knl_pkg::t_cell_ctl           i_ctl,
    input  logic [knl_pkg::DIST_W-1:0]   i_cand_dist,
    input  logic [INDEX_WIDTH-1:0]       i_cand_idx,
    input  logic                         i_prev_shift,
    input  logic [knl_pkg::DIST_W-1:0]   i_prev_dist,
    input  logic [INDEX_WIDTH-1:0]       i_prev_idx,
    output knl_pkg::t_cell_sts           o_sts,
    output logic [knl_pkg::DIST_W-1:0]   o_dist,
    output logic [INDEX_WIDTH-1:0]       o_idx
);
    import knl_pkg::*;

    logic [DIST_W-1:0]      r_dist;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic [DIST_W-1:0]      n_dist;
    logic [INDEX_WIDTH-1:0] n_idx;
    t_cell_sts              r_sts;
    t_cell_sts              n_sts;
    logic                   w_gt;

    assign w_gt = r_dist > i_cand_dist;

    always_comb begin
        n_sts.gt    = i_ctl.occupied & w_gt;
        n_sts.eq    = i_ctl.occupied & (r_dist == i_cand_dist);
        n_sts.shift = i_ctl.boundary | (i_ctl.below & w_gt);
        // lower neighbor moves up, or the candidate lands here
        n_dist = i_prev_shift ? i_prev_dist : i_cand_dist;
        n_idx  = i_prev_shift ? i_prev_idx  : i_cand_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_sts <= n_sts;
        end
        if (i_ctl.upd && r_sts.shift) begin
            r_dist <= n_dist;
            r_idx  <= n_idx;
        end
    end

    assign o_sts  = r_sts;
    assign o_dist = r_dist;
    assign o_idx  = r_idx;

endmodule

// File: hdl/k_nearest_result_list_top.sv
// ----------------------------------------------------------------------------
// k_nearest_result_list_top
// sorted list of the best nearest-neighbor candidates, built as a row of cells
// ----------------------------------------------------------------------------
// The list is a row of MAX_ENTRIES cells, cell 0 holding the nearest entry.
// Ops are taken one at a time. An add runs these steps: the beat is taken,
// every cell compares its distance with the candidate, the cells from the
// insertion point up to the boundary take the entry of their lower neighbor
// (the cell at the insertion point takes the candidate), and the result beat
// is built from the new worst entry. A read out gives one beat per held entry
// (one beat when the list is empty); a clear gives one beat. Unused op code 3
// is taken and gives no beat. A stalled result port holds the sequencer at
// its result or read-out step. The capacity register lies at byte address 0;
// 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES. An add whose
// distance equals a held one is rejected.
// ----------------------------------------------------------------------------
module k_nearest_result_list_top #(
    parameter int MAX_ENTRIES = knl_pkg::MAX_ENTRIES_DEF,
    parameter int INDEX_WIDTH = knl_pkg::INDEX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    knl_in_if.sink                             i_in,
    knl_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [knl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [knl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [knl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import knl_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_RES  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;

    // control state
    logic [2:0]             r_state, n_state;
    logic [OP_W-1:0]        r_op, n_op;
    logic [CW-1:0]          r_count, n_count;
    logic [CAP_W-1:0]       r_capacity;
    logic [DIST_W-1:0]      r_worst, n_worst;
    logic                   r_acc, n_acc;
    logic [PW-1:0]          r_pos, n_pos;

    // candidate held during the add
    logic [DIST_W-1:0]      r_dist;
    logic [INDEX_WIDTH-1:0] r_idx;

    // result register
    logic                   r_ovalid, n_ovalid;
    logic                   r_o_acc, n_o_acc;
    logic [CNT_OUT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [DIST_W-1:0]      r_o_worst, n_o_worst;
    logic [DIST_W-1:0]      r_o_edist, n_o_edist;
    logic [INDEX_WIDTH-1:0] r_o_eidx, n_o_eidx;
    logic [POS_OUT_W-1:0]   r_o_pos, n_o_pos;
    logic                   r_o_ev, n_o_ev;
    logic                   r_o_last, n_o_last;

    // cell row
    t_cell_ctl              w_ctl  [MAX_ENTRIES];
    t_cell_sts              w_sts  [MAX_ENTRIES];
    logic [DIST_W-1:0]      w_cdist[MAX_ENTRIES];
    logic [INDEX_WIDTH-1:0] w_cidx [MAX_ENTRIES];

    logic [CW-1:0]          w_cap_eff;
    logic                   w_full;
    logic [CW-1:0]          w_bound;
    logic                   w_dup;
    logic                   w_any_gt;
    logic                   w_accept;
    logic                   w_slot_free;
    logic                   w_in_beat;
    logic [PW-1:0]          w_raddr;
    logic [DIST_W-1:0]      w_rd_dist;
    logic [INDEX_WIDTH-1:0] w_rd_idx;
    logic                   w_rd_last;
    logic                   w_cfg_wr;
    logic                   w_sorted;

    // effective capacity: zero acts as one, saturate at the row length
    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = CW'(1);
        end else if (32'(r_capacity) > MAX_ENTRIES) begin
            w_cap_eff = CW'(MAX_ENTRIES);
        end else begin
            w_cap_eff = CW'(r_capacity);
        end
    end

    // when full the worst cell is overwritten, so the boundary is the worst cell
    assign w_full  = r_count >= w_cap_eff;
    assign w_bound = w_full ? (r_count - CW'(1)) : r_count;

    // broadcast and per-rank control into the row
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        logic                   w_prev_shift;
        logic [DIST_W-1:0]      w_prev_dist;
        logic [INDEX_WIDTH-1:0] w_prev_idx;

        always_comb begin
            w_ctl[gi].occupied = CW'(gi) < r_count;
            w_ctl[gi].below    = CW'(gi) < w_bound;
            w_ctl[gi].boundary = CW'(gi) == w_bound;
            w_ctl[gi].cmp      = r_state == ST_CMP;
            w_ctl[gi].upd      = (r_state == ST_UPD) && w_accept;
        end

        if (gi == 0) begin : g_head
            // the nearest cell has no lower neighbor
            assign w_prev_shift = 1'b0;
            assign w_prev_dist  = r_dist;
            assign w_prev_idx   = r_idx;
        end else begin : g_link
            assign w_prev_shift = w_sts[gi-1].shift;
            assign w_prev_dist  = w_cdist[gi-1];
            assign w_prev_idx   = w_cidx[gi-1];
        end

        knl_cell #(
            .INDEX_WIDTH (INDEX_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[gi]),
            .i_cand_dist  (r_dist),
            .i_cand_idx   (r_idx),
            .i_prev_shift (w_prev_shift),
            .i_prev_dist  (w_prev_dist),
            .i_prev_idx   (w_prev_idx),
            .o_sts        (w_sts[gi]),
            .o_dist       (w_cdist[gi]),
            .o_idx        (w_cidx[gi])
        );
    end

    // duplicate and worst-above-candidate flags gathered from the row
    always_comb begin
        w_dup    = 1'b0;
        w_any_gt = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_dup    = w_dup    | w_sts[i].eq;
            w_any_gt = w_any_gt | w_sts[i].gt;
        end
    end

    // list is sorted, so some entry above the candidate means the worst is
    assign w_accept = !w_dup && (!w_full || w_any_gt);

    // single read port on the row: worst rank after an add, else read-out rank
    assign w_raddr   = (r_state == ST_RES) ? PW'(r_count - CW'(1)) : r_pos;
    assign w_rd_dist = w_cdist[w_raddr];
    assign w_rd_idx  = w_cidx[w_raddr];
    assign w_rd_last = (CW'(r_pos) + CW'(1)) == r_count;

    assign w_slot_free = !r_ovalid || o_out.ready;
    assign i_in.ready  = r_state == ST_IDLE;
    assign w_in_beat   = i_in.valid && (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_count   = r_count;
        n_worst   = r_worst;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_o_acc   = r_o_acc;
        n_o_cnt   = r_o_cnt;
        n_o_worst = r_o_worst;
        n_o_edist = r_o_edist;
        n_o_eidx  = r_o_eidx;
        n_o_pos   = r_o_pos;
        n_o_ev    = r_o_ev;
        n_o_last  = r_o_last;

        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    n_op  = i_in.op;
                    n_pos = '0;
                    case (i_in.op)
                        OP_ADD: begin
                            n_state = ST_CMP;
                        end
                        OP_READ: begin
                            n_state = ST_RD;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_worst = '0;
                            n_state = ST_RES;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                // cells shift this cycle; count grows on an accepted add unless the worst was replaced
                n_acc = w_accept;
                if (w_accept && !w_full) begin
                    n_count = r_count + CW'(1);
                end
                n_state = ST_RES;
            end
            ST_RES: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_o_edist = '0;
                    n_o_eidx  = '0;
                    n_o_pos   = '0;
                    n_o_ev    = 1'b0;
                    n_o_last  = 1'b1;
                    if (r_op == OP_ADD) begin
                        n_worst   = (r_count == '0) ? '0 : w_rd_dist;
                        n_o_acc   = r_acc;
                        n_o_cnt   = CNT_OUT_W'(r_count);
                        n_o_worst = n_worst;
                    end else begin
                        n_o_acc   = 1'b0;
                        n_o_cnt   = '0;
                        n_o_worst = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_o_acc  = 1'b0;
                    if (r_count == '0) begin
                        // empty list gives one blank beat
                        n_o_cnt   = '0;
                        n_o_worst = '0;
                        n_o_edist = '0;
                        n_o_eidx  = '0;
                        n_o_pos   = '0;
                        n_o_ev    = 1'b0;
                        n_o_last  = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_o_cnt   = CNT_OUT_W'(r_count);
                        n_o_worst = r_worst;
                        n_o_edist = w_rd_dist;
                        n_o_eidx  = w_rd_idx;
                        n_o_pos   = POS_OUT_W'(r_pos);
                        n_o_ev    = 1'b1;
                        n_o_last  = w_rd_last;
                        n_pos     = r_pos + PW'(1);
                        if (w_rd_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // capacity register
    assign w_cfg_wr = psel && penable && pwrite &&
                      (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ?
                      APB_DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_worst    <= '0;
            r_pos      <= '0;
            r_ovalid   <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_worst  <= n_worst;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
            if (w_cfg_wr) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_acc     <= n_acc;
        r_o_acc   <= n_o_acc;
        r_o_cnt   <= n_o_cnt;
        r_o_worst <= n_o_worst;
        r_o_edist <= n_o_edist;
        r_o_eidx  <= n_o_eidx;
        r_o_pos   <= n_o_pos;
        r_o_ev    <= n_o_ev;
        r_o_last  <= n_o_last;
        if (w_in_beat) begin
            r_dist <= i_in.distance;
            r_idx  <= i_in.point_index;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.accepted       = r_o_acc;
    assign o_out.entry_count    = r_o_cnt;
    assign o_out.worst_distance = r_o_worst;
    assign o_out.entry_distance = r_o_edist;
    assign o_out.entry_index    = r_o_eidx;
    assign o_out.position       = r_o_pos;
    assign o_out.entry_valid    = r_o_ev;
    assign o_out.last           = r_o_last;

    // held entries strictly ascending, checked while idle
    always_comb begin
        w_sorted = 1'b1;
        for (int i = 1; i < MAX_ENTRIES; i++) begin
            if ((CW'(i) < r_count) && !(w_cdist[i-1] < w_cdist[i])) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ENTRIES)
        else $error("entry count beyond row length");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> w_sorted)
        else $error("held entries not strictly ascending");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ($past(r_state) == ST_UPD || $past(r_state) == ST_IDLE))
        else $error("entry count changed outside update or clear");

    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RES && r_op == OP_ADD && w_slot_free) |=>
        (r_ovalid && r_o_last && !r_o_ev))
        else $error("add result beat malformed");

endmodule

// File: sim/k_nearest_result_list_top_tb.sv
// ----------------------------------------------------------------------------
// k_nearest_result_list_top_tb
// self-checking bench for the sorted k-nearest candidate list
// ----------------------------------------------------------------------------
// Ops go in through a queue-fed sender and result beats are checked against
// a model of the sorted list kept in a scoreboard class. A directed opening
// covers empty read out, clear, duplicate distances, distance and index
// extremes, the unused op code, capacity 0 and 1, and a capacity lowered
// below the held count. Three random phases follow with different idle
// patterns on each side, one of them with a long result stall so the op
// channel backs up. The capacity register is written only while idle.
// ----------------------------------------------------------------------------
module k_nearest_result_list_top_tb
    import knl_pkg::*;
();

    localparam int LIST_DEPTH     = MAX_ENTRIES_DEF;
    localparam int IDX_W          = INDEX_WIDTH_DEF;
    localparam int PHASE_ITEMS    = 28;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [OP_W-1:0]       OP_UNUSED     = 2'd3;
    localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = APB_ADDR_W'({REG_CAPACITY, 2'b00});

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  point_index;
    } t_list_op;

    typedef struct packed {
        logic                 accepted;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [DIST_W-1:0]    worst_distance;
        logic [DIST_W-1:0]    entry_distance;
        logic [IDX_W-1:0]     entry_index;
        logic [POS_OUT_W-1:0] position;
        logic                 entry_valid;
        logic                 last;
    } t_list_beat;

    // shadow of the sorted list plus the result beats still owed by the block
    class nearest_list_tracker;
        logic [DIST_W-1:0] held_dist [LIST_DEPTH];
        logic [IDX_W-1:0]  held_idx  [LIST_DEPTH];
        int unsigned       held_count;
        logic [CAP_W-1:0]  capacity;
        t_list_beat        pending_beats [$];
        int                errors;

        function new();
            held_count = 0;
            capacity   = CAP_RESET;
            errors     = 0;
        endfunction

        function int unsigned limit();
            if (capacity == 0) return 1;
            if (capacity > LIST_DEPTH) return LIST_DEPTH;
            return capacity;
        endfunction

        function logic [DIST_W-1:0] worst();
            if (held_count == 0) return '0;
            return held_dist[held_count-1];
        endfunction

        // insert into the sorted prefix of length n
        function void insert_sorted(int unsigned n, logic [DIST_W-1:0] d,
                                    logic [IDX_W-1:0] idx);
            int unsigned p;
            p = n;
            while (p > 0 && held_dist[p-1] > d) begin
                held_dist[p] = held_dist[p-1];
                held_idx[p]  = held_idx[p-1];
                p--;
            end
            held_dist[p] = d;
            held_idx[p]  = idx;
        endfunction

        function void note_op(t_list_op item);
            t_list_beat  b;
            bit          dup;
            int unsigned i;
            b      = '0;
            b.last = 1'b1;
            dup    = 1'b0;
            case (item.op)
                OP_ADD: begin
                    for (i = 0; i < held_count; i++)
                        if (held_dist[i] == item.distance) dup = 1'b1;
                    if (!dup) begin
                        if (held_count < limit()) begin
                            insert_sorted(held_count, item.distance, item.point_index);
                            held_count++;
                            b.accepted = 1'b1;
                        end else if (held_count > 0 && worst() > item.distance) begin
                            // full: the worst entry drops out
                            insert_sorted(held_count - 1, item.distance, item.point_index);
                            b.accepted = 1'b1;
                        end
                    end
                    b.entry_count    = CNT_OUT_W'(held_count);
                    b.worst_distance = worst();
                    pending_beats = {pending_beats, b};
                end
                OP_READ: begin
                    if (held_count == 0) begin
                        pending_beats = {pending_beats, b};
                    end else begin
                        for (i = 0; i < held_count; i++) begin
                            b.entry_count    = CNT_OUT_W'(held_count);
                            b.worst_distance = worst();
                            b.entry_distance = held_dist[i];
                            b.entry_index    = held_idx[i];
                            b.position       = POS_OUT_W'(i);
                            b.entry_valid    = 1'b1;
                            b.last           = (i + 1 == held_count);
                            pending_beats = {pending_beats, b};
                        end
                    end
                end
                OP_CLEAR: begin
                    held_count = 0;
                    pending_beats = {pending_beats, b};
                end
                default: ;
            endcase
        endfunction

        function int compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s expected %0h got %0h", name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_beat(t_list_beat got);
            t_list_beat want;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            errors += compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
            errors += compare_field("entry_count", 64'(want.entry_count),
                                    64'(got.entry_count));
            errors += compare_field("worst_distance", 64'(want.worst_distance),
                                    64'(got.worst_distance));
            errors += compare_field("entry_distance", 64'(want.entry_distance),
                                    64'(got.entry_distance));
            errors += compare_field("entry_index", 64'(want.entry_index),
                                    64'(got.entry_index));
            errors += compare_field("position", 64'(want.position), 64'(got.position));
            errors += compare_field("entry_valid", 64'(want.entry_valid),
                                    64'(got.entry_valid));
            errors += compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    knl_in_if  #(.INDEX_WIDTH(IDX_W)) in_bus ();
    knl_out_if #(.INDEX_WIDTH(IDX_W)) out_bus ();

    k_nearest_result_list_top #(
        .MAX_ENTRIES(LIST_DEPTH),
        .INDEX_WIDTH(IDX_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nearest_list_tracker tracker = new();

    t_list_op    op_queue [$];   // ops waiting for the sender
    int unsigned ops_queued;
    int unsigned ops_taken;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          hold_request;   // asks the receiver for one long stall
    int unsigned quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // op sender: one beat at a time from the queue, random idle cycles between
    initial begin : op_sender
        t_list_op item;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (op_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                item = op_queue.pop_front();
                in_bus.valid       <= 1'b1;
                in_bus.op          <= item.op;
                in_bus.distance    <= item.distance;
                in_bus.point_index <= item.point_index;
                @(posedge i_clk);
                while (!in_bus.ready) @(posedge i_clk);
                ops_taken++;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver: random back-pressure, plus one long stall on request
    initial begin : beat_receiver
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_bus.ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // monitor: predict on every op beat, check every result beat, and watch
    // for a stretch with no beat at all
    always @(posedge i_clk) begin : beat_monitor
        t_list_op   op_seen;
        t_list_beat beat_seen;
        bit         moved;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (in_bus.valid && in_bus.ready) begin
                op_seen.op          = in_bus.op;
                op_seen.distance    = in_bus.distance;
                op_seen.point_index = in_bus.point_index;
                tracker.note_op(op_seen);
                moved = 1'b1;
            end
            if (out_bus.valid && out_bus.ready) begin
                beat_seen.accepted       = out_bus.accepted;
                beat_seen.entry_count    = out_bus.entry_count;
                beat_seen.worst_distance = out_bus.worst_distance;
                beat_seen.entry_distance = out_bus.entry_distance;
                beat_seen.entry_index    = out_bus.entry_index;
                beat_seen.position       = out_bus.position;
                beat_seen.entry_valid    = out_bus.entry_valid;
                beat_seen.last           = out_bus.last;
                tracker.check_beat(beat_seen);
                moved = 1'b1;
            end
            if (moved) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic queue_op(logic [OP_W-1:0] op, logic [DIST_W-1:0] distance,
                            logic [31:0] point);
        t_list_op item;
        item.op          = op;
        item.distance    = distance;
        item.point_index = point[IDX_W-1:0];
        op_queue = {op_queue, item};
        ops_queued++;
    endtask

    // every op taken, every result beat in, then a settle wait for an unused
    // op that gives no beat
    task automatic drain_list_ops();
        while (ops_taken != ops_queued || tracker.pending_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write the capacity register, then read it back
    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.capacity = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_W'(value)) begin
            $error("capacity readback expected %0h got %0h", value, prdata);
            tracker.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random runs: mostly clear, a batch of adds around a shared base so
    // duplicates and replacements happen, then a read out; some runs skip
    // the clear, and stray reads and unused ops are mixed in
    task automatic run_random_phase(int unsigned tx_pct, int unsigned rx_pct,
                                    logic [CAP_W-1:0] cap, bit long_hold);
        int unsigned       counted;
        int unsigned       run_len;
        int unsigned       i;
        int unsigned       pick;
        logic [DIST_W-1:0] base;
        logic [DIST_W-1:0] d;
        drain_list_ops();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_capacity(cap);
        if (long_hold) hold_request = 1'b1;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            if (counted == 0 || $urandom_range(0, 3) != 0) begin
                queue_op(OP_CLEAR, $urandom, $urandom);
                counted++;
            end
            run_len = $urandom_range(1, tracker.limit() + 4);
            base    = $urandom;
            for (i = 0; i < run_len; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) d = base + $urandom_range(0, 2 * run_len);
                else if (pick < 8) d = $urandom;
                else if (pick == 8) d = '0;
                else d = '1;
                queue_op(OP_ADD, d, $urandom);
                counted++;
                if ($urandom_range(0, 7) == 0) begin
                    queue_op(OP_READ, $urandom, $urandom);
                    counted++;
                end
                if ($urandom_range(0, 11) == 0) queue_op(OP_UNUSED, $urandom, $urandom);
            end
            queue_op(OP_READ, $urandom, $urandom);
            counted++;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.op          = OP_ADD;
        in_bus.distance    = '0;
        in_bus.point_index = '0;
        out_bus.ready      = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        ops_queued         = 0;
        ops_taken          = 0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        hold_request       = 1'b0;
        quiet_cycles       = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity: empty read out, clear with junk payload,
        // distance and index extremes, a duplicate of zero, unused op
        queue_op(OP_READ, 32'h0, 32'h0);
        queue_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFF_FFFF);
        queue_op(OP_ADD, 32'h0, 32'h0);
        queue_op(OP_ADD, 32'hFFFF_FFFF, 32'hFF_FFFF);
        queue_op(OP_ADD, 32'h0, 32'h00_005A);
        queue_op(OP_ADD, 32'h0001_0000, 32'h12_3456);
        queue_op(OP_READ, 32'h0, 32'h0);
        queue_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFF_FFFF);
        queue_op(OP_CLEAR, 32'h0, 32'h0);
        queue_op(OP_READ, 32'h0, 32'h0);

        // capacity 1: replace the single entry, reject larger and equal
        drain_list_ops();
        write_capacity(CAP_W'(1));
        queue_op(OP_ADD, 32'h0005_0000, 32'h1);
        queue_op(OP_ADD, 32'h0003_0000, 32'h2);
        queue_op(OP_ADD, 32'h0004_0000, 32'h3);
        queue_op(OP_ADD, 32'h0003_0000, 32'h4);
        queue_op(OP_READ, 32'h0, 32'h0);

        // capacity 0 behaves as 1
        drain_list_ops();
        write_capacity(CAP_W'(0));
        queue_op(OP_CLEAR, 32'h0, 32'h0);
        queue_op(OP_ADD, 32'h7, 32'h5);
        queue_op(OP_ADD, 32'h3, 32'h6);
        queue_op(OP_READ, 32'h0, 32'h0);

        // fill four entries out of order, then lower the capacity to 2:
        // nothing drops, adds can only replace the worst one
        drain_list_ops();
        write_capacity(CAP_W'(16));
        queue_op(OP_CLEAR, 32'h0, 32'h0);
        queue_op(OP_ADD, 32'd40, 32'h10);
        queue_op(OP_ADD, 32'd10, 32'h11);
        queue_op(OP_ADD, 32'd30, 32'h12);
        queue_op(OP_ADD, 32'd20, 32'h13);
        drain_list_ops();
        write_capacity(CAP_W'(2));
        queue_op(OP_ADD, 32'd25, 32'h14);
        queue_op(OP_ADD, 32'd50, 32'h15);
        queue_op(OP_ADD, 32'd10, 32'h16);
        queue_op(OP_READ, 32'h0, 32'h0);

        // random part: slow receiver, then slow sender, then full rate with
        // one long result stall and a capacity that saturates
        run_random_phase(15, 83, CAP_W'($urandom_range(1, 6)), 1'b0);
        run_random_phase(83, 15, CAP_W'($urandom_range(1, 16)), 1'b0);
        run_random_phase(0, 0, CAP_W'(31), 1'b1);

        drain_list_ops();
        repeat (20) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
